// ===== rtl/dsp_pkg.sv =====
// package: types, codes and unit tables for the duration string parser
`timescale 1ns / 1ps

package dsp_pkg;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_UNIT_NO_NUM = 3'd1;
   localparam logic [2:0] ST_BAD_CHAR    = 3'd2;
   localparam logic [2:0] ST_NUM_NO_UNIT = 3'd3;
   localparam logic [2:0] ST_TOO_SHORT   = 3'd4;

   // unit slots in summing order
   localparam int UNIT_COUNT = 6;
   localparam logic [2:0] UNIT_Y = 3'd0;
   localparam logic [2:0] UNIT_W = 3'd1;
   localparam logic [2:0] UNIT_D = 3'd2;
   localparam logic [2:0] UNIT_H = 3'd3;
   localparam logic [2:0] UNIT_M = 3'd4;
   localparam logic [2:0] UNIT_S = 3'd5;

   // character codes
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_CASE    = 8'h20;
   localparam logic [7:0] CH_Y       = 8'h79;
   localparam logic [7:0] CH_W       = 8'h77;
   localparam logic [7:0] CH_D       = 8'h64;
   localparam logic [7:0] CH_H       = 8'h68;
   localparam logic [7:0] CH_M       = 8'h6D;
   localparam logic [7:0] CH_S       = 8'h73;

   localparam logic [31:0] MAX32         = 32'hFFFF_FFFF;
   localparam logic [31:0] MIN_RESET     = 32'd10;
   localparam int          SUM_W         = 35;
   localparam logic [1:0]  ADDR_MIN_DUR  = 2'd0;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] seconds;
      logic [2:0]  status;
   } rsp_type;

   // result settled before the final sum
   typedef struct packed {
      logic        done;
      logic [31:0] seconds;
      logic [2:0]  status;
   } early_type;

   // seconds per unit
   function automatic logic [31:0] unit_weight(input logic [2:0] idx);
      logic [31:0] w;
      unique case (idx)
         UNIT_Y:  w = 32'd31556952;
         UNIT_W:  w = 32'd604800;
         UNIT_D:  w = 32'd86400;
         UNIT_H:  w = 32'd3600;
         UNIT_M:  w = 32'd60;
         UNIT_S:  w = 32'd1;
         default: w = 32'd0;
      endcase
      return w;
   endfunction

   // largest count whose weighted value still fits
   function automatic logic [31:0] unit_limit(input logic [2:0] idx);
      logic [31:0] l;
      unique case (idx)
         UNIT_Y:  l = 32'd136;
         UNIT_W:  l = 32'd7101;
         UNIT_D:  l = 32'd49710;
         UNIT_H:  l = 32'd1193046;
         UNIT_M:  l = 32'd71582788;
         UNIT_S:  l = 32'd4294967295;
         default: l = 32'd0;
      endcase
      return l;
   endfunction

endpackage

// ===== rtl/duration_string_parser_unit.sv =====
// top level: duration text parser with pipelined weighted sum
`timescale 1ns / 1ps

// Parses a duration text such as 1d2h30m, one character per word on the
// req channel; the word with last set closes the text. One rsp word
// (seconds, status) comes out per text, in order.
// The minimum duration register sits at byte address 0 of the APB-style
// port; pready is always high.
// Throughput: one character per cycle; a closing character waits while the
// product snapshot stage is full and stalled. The per-character work (times
// ten plus digit, or one constant multiply into a unit slot) is done between
// the input register and the parse state registers. A text's result passes
// the input register, product snapshot, two adder stages, prefix stage, then
// the select and minimum compare into the output register. Empty stages are
// filled while the output waits, so characters keep being taken during an
// rsp stall; only a closing character waits once the pipeline is full.
// Reset clears the parse state and all stage valids and sets the minimum
// duration to 10.
module duration_string_parser_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dsp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dsp_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [1:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int SW = dsp_pkg::SUM_W;

   // configuration register
   logic [31:0] min_dur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dur_ff <= dsp_pkg::MIN_RESET;
      end else if (psel && penable && pwrite && pready && paddr == dsp_pkg::ADDR_MIN_DUR) begin
         min_dur_ff <= pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == dsp_pkg::ADDR_MIN_DUR) ? min_dur_ff : 32'd0;

   // stage valids and readies
   logic in_vld_ff, c1_vld_ff, c2_vld_ff, c3_vld_ff, c4_vld_ff, out_vld_ff;
   logic c1_rdy, c2_rdy, c3_rdy, c4_rdy, out_rdy;
   logic in_fire;
   dsp_pkg::req_type in_data_ff;

   assign out_rdy   = !out_vld_ff || rsp_ready;
   assign c4_rdy    = !c4_vld_ff || out_rdy;
   assign c3_rdy    = !c3_vld_ff || c4_rdy;
   assign c2_rdy    = !c2_vld_ff || c3_rdy;
   assign c1_rdy    = !c1_vld_ff || c2_rdy;
   assign in_fire   = in_vld_ff && (!in_data_ff.last || c1_rdy);
   assign req_ready = !in_vld_ff || in_fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // parse state
   logic [31:0] acc_ff, acc_in;
   logic        exp_ff, exp_in;
   logic        fin_ff, fin_in;
   logic [31:0] held_sec_ff, held_sec_in;
   logic [2:0]  held_st_ff, held_st_in;
   logic [31:0] prod_ff [dsp_pkg::UNIT_COUNT];
   logic [31:0] prod_in [dsp_pkg::UNIT_COUNT];

   // character decode
   logic [7:0]  ch;
   logic [7:0]  lc;
   logic        is_digit;
   logic        unit_hit;
   logic [2:0]  unit_idx;
   logic [35:0] acc_next;
   logic [31:0] product;
   logic [31:0] limit;

   assign ch       = in_data_ff.char_code;
   assign is_digit = (ch >= dsp_pkg::CH_DIGIT_0) && (ch <= dsp_pkg::CH_DIGIT_9);
   assign lc       = ((ch >= dsp_pkg::CH_UPPER_A) && (ch <= dsp_pkg::CH_UPPER_Z)) ?
                     (ch | dsp_pkg::CH_CASE) : ch;

   always_comb begin
      unit_hit = 1'b1;
      unique case (lc)
         dsp_pkg::CH_Y: unit_idx = dsp_pkg::UNIT_Y;
         dsp_pkg::CH_W: unit_idx = dsp_pkg::UNIT_W;
         dsp_pkg::CH_D: unit_idx = dsp_pkg::UNIT_D;
         dsp_pkg::CH_H: unit_idx = dsp_pkg::UNIT_H;
         dsp_pkg::CH_M: unit_idx = dsp_pkg::UNIT_M;
         dsp_pkg::CH_S: unit_idx = dsp_pkg::UNIT_S;
         default: begin
            unit_idx = dsp_pkg::UNIT_Y;
            unit_hit = 1'b0;
         end
      endcase
   end

   // times ten plus digit, and weighted count for a unit
   // (a count below the unit limit keeps the product within 32 bits)
   assign acc_next = {1'b0, acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0}
                   + {32'd0, ch[3:0] - dsp_pkg::CH_DIGIT_0[3:0]};
   assign product  = acc_ff * dsp_pkg::unit_weight(unit_idx);
   assign limit    = dsp_pkg::unit_limit(unit_idx);

   // next parse state for the character in the input register
   always_comb begin
      acc_in      = acc_ff;
      exp_in      = exp_ff;
      fin_in      = fin_ff;
      held_sec_in = held_sec_ff;
      held_st_in  = held_st_ff;
      for (int i = 0; i < dsp_pkg::UNIT_COUNT; i++) begin
         prod_in[i] = prod_ff[i];
      end
      if (!fin_ff) begin
         priority if (is_digit) begin
            exp_in = 1'b0;
            if (acc_next[35:32] != 4'd0) begin
               fin_in      = 1'b1;
               held_sec_in = acc_ff;
               held_st_in  = dsp_pkg::ST_OK;
            end else begin
               acc_in = acc_next[31:0];
            end
         end else if (!unit_hit) begin
            fin_in      = 1'b1;
            held_sec_in = 32'd0;
            held_st_in  = dsp_pkg::ST_BAD_CHAR;
         end else if (exp_ff) begin
            fin_in      = 1'b1;
            held_sec_in = 32'd0;
            held_st_in  = dsp_pkg::ST_UNIT_NO_NUM;
         end else if (acc_ff >= limit) begin
            fin_in      = 1'b1;
            held_sec_in = dsp_pkg::MAX32;
            held_st_in  = dsp_pkg::ST_OK;
         end else begin
            for (int i = 0; i < dsp_pkg::UNIT_COUNT; i++) begin
               if (unit_idx == 3'(i)) begin
                  prod_in[i] = product;
               end
            end
            acc_in = 32'd0;
            exp_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (in_fire && in_data_ff.last)) begin
         acc_ff      <= 32'd0;
         exp_ff      <= 1'b1;
         fin_ff      <= 1'b0;
         held_sec_ff <= 32'd0;
         held_st_ff  <= dsp_pkg::ST_OK;
         for (int i = 0; i < dsp_pkg::UNIT_COUNT; i++) begin
            prod_ff[i] <= 32'd0;
         end
      end else if (in_fire) begin
         acc_ff      <= acc_in;
         exp_ff      <= exp_in;
         fin_ff      <= fin_in;
         held_sec_ff <= held_sec_in;
         held_st_ff  <= held_st_in;
         for (int i = 0; i < dsp_pkg::UNIT_COUNT; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   // result settled at close time, if any
   dsp_pkg::early_type close_early;

   always_comb begin
      close_early.done    = 1'b0;
      close_early.seconds = 32'd0;
      close_early.status  = dsp_pkg::ST_OK;
      if (fin_in) begin
         close_early.done    = 1'b1;
         close_early.seconds = held_sec_in;
         close_early.status  = held_st_in;
      end else if (!exp_in) begin
         close_early.done    = 1'b1;
         close_early.status  = dsp_pkg::ST_NUM_NO_UNIT;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff  <= 1'b0;
         c2_vld_ff  <= 1'b0;
         c3_vld_ff  <= 1'b0;
         c4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (c1_rdy) begin
            c1_vld_ff <= in_vld_ff && in_data_ff.last;
         end
         if (c2_rdy) begin
            c2_vld_ff <= c1_vld_ff;
         end
         if (c3_rdy) begin
            c3_vld_ff <= c2_vld_ff;
         end
         if (c4_rdy) begin
            c4_vld_ff <= c3_vld_ff;
         end
         if (out_rdy) begin
            out_vld_ff <= c4_vld_ff;
         end
      end
   end

   // stage 1: product snapshot
   dsp_pkg::early_type c1_early_ff;
   logic [31:0] c1_prod_ff [dsp_pkg::UNIT_COUNT];

   always_ff @(posedge clock) begin
      if (c1_rdy) begin
         c1_early_ff <= close_early;
         for (int i = 0; i < dsp_pkg::UNIT_COUNT; i++) begin
            c1_prod_ff[i] <= prod_in[i];
         end
      end
   end

   // stage 2: pair sums
   dsp_pkg::early_type c2_early_ff;
   logic [SW-1:0] c2_a_ff, c2_b_ff, c2_c_ff, c2_p0_ff, c2_p2_ff, c2_p4_ff;

   always_ff @(posedge clock) begin
      if (c2_rdy) begin
         c2_early_ff <= c1_early_ff;
         c2_a_ff     <= SW'(c1_prod_ff[0]) + SW'(c1_prod_ff[1]);
         c2_b_ff     <= SW'(c1_prod_ff[2]) + SW'(c1_prod_ff[3]);
         c2_c_ff     <= SW'(c1_prod_ff[4]) + SW'(c1_prod_ff[5]);
         c2_p0_ff    <= SW'(c1_prod_ff[0]);
         c2_p2_ff    <= SW'(c1_prod_ff[2]);
         c2_p4_ff    <= SW'(c1_prod_ff[4]);
      end
   end

   // stage 3: prefix sums up to the hour part
   dsp_pkg::early_type c3_early_ff;
   logic [SW-1:0] c3_s1_ff, c3_s2_ff, c3_s3_ff, c3_s4_ff, c3_p4_ff, c3_c_ff;

   always_ff @(posedge clock) begin
      if (c3_rdy) begin
         c3_early_ff <= c2_early_ff;
         c3_s1_ff    <= c2_p0_ff;
         c3_s2_ff    <= c2_a_ff;
         c3_s3_ff    <= c2_a_ff + c2_p2_ff;
         c3_s4_ff    <= c2_a_ff + c2_b_ff;
         c3_p4_ff    <= c2_p4_ff;
         c3_c_ff     <= c2_c_ff;
      end
   end

   // stage 4: remaining prefix sums
   dsp_pkg::early_type c4_early_ff;
   logic [SW-1:0] c4_s_ff [dsp_pkg::UNIT_COUNT];

   always_ff @(posedge clock) begin
      if (c4_rdy) begin
         c4_early_ff <= c3_early_ff;
         c4_s_ff[0]  <= c3_s1_ff;
         c4_s_ff[1]  <= c3_s2_ff;
         c4_s_ff[2]  <= c3_s3_ff;
         c4_s_ff[3]  <= c3_s4_ff;
         c4_s_ff[4]  <= c3_s4_ff + c3_p4_ff;
         c4_s_ff[5]  <= c3_s4_ff + c3_c_ff;
      end
   end

   // longest prefix that still fits; sums only grow, so the last fit wins
   logic [31:0]      total;
   dsp_pkg::rsp_type rsp_in;
   dsp_pkg::rsp_type rsp_data_ff;

   always_comb begin
      total = 32'd0;
      for (int i = 0; i < dsp_pkg::UNIT_COUNT; i++) begin
         if (c4_s_ff[i][SW-1:32] == '0) begin
            total = c4_s_ff[i][31:0];
         end
      end
      if (c4_early_ff.done) begin
         rsp_in.seconds = c4_early_ff.seconds;
         rsp_in.status  = c4_early_ff.status;
      end else if (total < min_dur_ff) begin
         rsp_in.seconds = 32'd0;
         rsp_in.status  = dsp_pkg::ST_TOO_SHORT;
      end else begin
         rsp_in.seconds = total;
         rsp_in.status  = dsp_pkg::ST_OK;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
